>>> rtl/bir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bir_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int MAX_CHANNELS   = 4;
  localparam int MAX_DST        = 4096;
  localparam int FRAC_BITS      = 8;
  localparam int SAMPLE_BITS    = 16;

  localparam int IDX_W   = $clog2(MAX_SRC_WIDTH);
  localparam int CH_W    = $clog2(MAX_CHANNELS);
  localparam int ADDR_W  = 2 * IDX_W + CH_W;
  localparam int DEPTH   = MAX_SRC_WIDTH * MAX_SRC_HEIGHT * MAX_CHANNELS;

  // divider: numerator carries the fraction bits in bilinear mode, denominator is 2*dst
  localparam int NUM_W   = 30;
  localparam int DEN_W   = 14;
  localparam int DIV_BPS = 2;
  localparam int DIV_STEPS = NUM_W / DIV_BPS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef enum logic [2:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_DST_WIDTH  = 3'd2,
    CFG_DST_HEIGHT = 3'd3,
    CFG_CHANNELS   = 3'd4,
    CFG_MODE       = 3'd5
  } cfg_reg_t;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

endpackage
`default_nettype wire

>>> rtl/bir_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

>>> rtl/bir_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, DIV_BPS quotient bits per cycle.
module bir_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [bir_pkg::NUM_W-1:0] num,
  input  wire logic [bir_pkg::DEN_W-1:0] den,
  output logic                           busy,
  output logic      [bir_pkg::NUM_W-1:0] quo
);

  logic [bir_pkg::DEN_W-1:0]     rem;
  logic [bir_pkg::DEN_W-1:0]     dvs;
  logic [bir_pkg::DIV_CNT_W-1:0] cnt;
  logic [bir_pkg::DEN_W-1:0]     rem_next;
  logic [bir_pkg::NUM_W-1:0]     quo_next;

  always_comb begin
    logic [bir_pkg::DEN_W:0] sh;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < bir_pkg::DIV_BPS; i++) begin
      sh = {rem_next, quo_next[bir_pkg::NUM_W-1]};
      if (sh >= {1'b0, dvs}) begin
        sh = sh - {1'b0, dvs};
        quo_next = {quo_next[bir_pkg::NUM_W-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[bir_pkg::NUM_W-2:0], 1'b0};
      end
      rem_next = sh[bir_pkg::DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
      quo  <= num;
      dvs  <= den;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt + 1'b1;
      if (cnt == bir_pkg::DIV_CNT_W'(bir_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/bilinear_image_resize.sv
// Image resize over a frame store, nearest or bilinear (half-pixel centres).
// Input channel (in_valid/in_ready): operation, pos_x, pos_y, chan, sample_in.
//   A load item writes one source sample and gives no result;
//   loads outside the configured source size are dropped.
// Output channel (out_valid/out_ready): sample_out, range_error, one item per
//   request. Requests outside the dest size or channels give 0 with range_error.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects the
//   register, cfg_data the value; write only while the block is idle.
// Pace: a request goes through one shared restoring divider (two quotient bits
//   a cycle, one division per axis after a multiply and a prep step), one
//   shared 24x9 multiplier and the single-port frame store (four reads for
//   bilinear); a range error skips the arithmetic. Loads are taken back to
//   back while idle.
// in_ready is high only when idle; a finished result sits in the output
//   register, and while the receiver stalls the next request completes its
//   arithmetic and then waits until that register frees.
// Reset: registers return to 256x256 source, 256x256 destination, one
//   channel, bilinear; the frame store is not cleared and must be loaded
//   before it is read.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_image_resize (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [11:0] pos_x,
  input  wire logic [11:0] pos_y,
  input  wire logic [1:0]  chan,
  input  wire logic [15:0] sample_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [15:0] sample_out,
  output logic             range_error,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_PREP, S_DIV, S_RD, S_ACC, S_BL0, S_BL1, S_RND, S_DONE
  } state_t;

  state_t state;

  // configuration registers, raw
  logic [8:0]  src_width, src_height;
  logic [12:0] dst_width, dst_height;
  logic [2:0]  channel_count;
  logic        interp_mode;

  // fitted sizes
  logic [8:0]  sw_f, sh_f;
  logic [12:0] dw_f, dh_f;
  logic [2:0]  ch_f;

  always_comb begin
    sw_f = (src_width == '0) ? 9'd1 :
           (src_width > 9'(bir_pkg::MAX_SRC_WIDTH)) ? 9'(bir_pkg::MAX_SRC_WIDTH) : src_width;
    sh_f = (src_height == '0) ? 9'd1 :
           (src_height > 9'(bir_pkg::MAX_SRC_HEIGHT)) ? 9'(bir_pkg::MAX_SRC_HEIGHT) : src_height;
    dw_f = (dst_width == '0) ? 13'd1 :
           (dst_width > 13'(bir_pkg::MAX_DST)) ? 13'(bir_pkg::MAX_DST) : dst_width;
    dh_f = (dst_height == '0) ? 13'd1 :
           (dst_height > 13'(bir_pkg::MAX_DST)) ? 13'(bir_pkg::MAX_DST) : dst_height;
    ch_f = (channel_count == '0) ? 3'd1 :
           (channel_count > 3'(bir_pkg::MAX_CHANNELS)) ? 3'(bir_pkg::MAX_CHANNELS) : channel_count;
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // latched request
  logic [11:0] req_x, req_y;
  logic [bir_pkg::CH_W-1:0] req_c;
  logic        axis;        // 0 columns, 1 rows
  logic [21:0] prod;        // (2*pos+1)*src
  logic        neg;         // half-pixel numerator below zero
  logic [bir_pkg::IDX_W-1:0] x0, x1, y0, y1;
  logic [bir_pkg::FRAC_BITS-1:0] fx, fy;
  logic [1:0]  cnt;         // corner being read
  logic [23:0] row, top, bot;
  logic [32:0] acc;

  // frame store read data
  logic [15:0] ram_rdata;

  // shared multiplier
  logic [23:0] mul_a;
  logic [8:0]  mul_b;
  logic [32:0] mul_p;
  logic [8:0]  wfx, wfy;

  assign wfx = 9'(1 << bir_pkg::FRAC_BITS) - {1'b0, fx};
  assign wfy = 9'(1 << bir_pkg::FRAC_BITS) - {1'b0, fy};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MUL: begin
        mul_a = {11'd0, (axis ? req_y : req_x), 1'b1};
        mul_b = axis ? sh_f : sw_f;
      end
      S_ACC: begin
        mul_a = {8'd0, ram_rdata};
        mul_b = cnt[0] ? {1'b0, fx} : wfx;
      end
      S_BL0: begin
        mul_a = top;
        mul_b = wfy;
      end
      S_BL1: begin
        mul_a = bot;
        mul_b = {1'b0, fy};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 33'(mul_a) * 33'(mul_b);

  // divider feed
  logic [12:0] dsel;
  logic [8:0]  ssel;
  logic        prep_neg;
  logic [21:0] prep_base;
  logic [bir_pkg::NUM_W-1:0] div_num;
  logic [bir_pkg::DEN_W-1:0] div_den;
  logic        div_start, div_busy;
  logic [bir_pkg::NUM_W-1:0] div_quo;

  always_comb begin
    dsel      = axis ? dh_f : dw_f;
    ssel      = axis ? sh_f : sw_f;
    prep_neg  = prod < {9'd0, dsel};
    prep_base = prep_neg ? prod + {9'd0, dsel} : prod - {9'd0, dsel};
    div_num   = (interp_mode == bir_pkg::MODE_NEAREST) ?
                bir_pkg::NUM_W'(prod) :
                bir_pkg::NUM_W'({prep_base, {bir_pkg::FRAC_BITS{1'b0}}});
    div_den   = {dsel, 1'b0};
    div_start = (state == S_PREP);
  end

  bir_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // neighbour indices after the division
  function automatic logic [bir_pkg::IDX_W-1:0] clamp_idx(input logic signed [22:0] v,
                                                          input logic [8:0] size);
    logic [8:0] last;
    last = size - 9'd1;
    if (v < 23'sd0) return '0;
    else if (v >= $signed({14'd0, size})) return last[bir_pkg::IDX_W-1:0];
    else return v[bir_pkg::IDX_W-1:0];
  endfunction

  logic signed [22:0] qv0, qv1;

  always_comb begin
    if (interp_mode == bir_pkg::MODE_NEAREST) begin
      qv0 = $signed({1'b0, div_quo[21:0]});
    end else begin
      qv0 = $signed({1'b0, div_quo[bir_pkg::NUM_W-1:bir_pkg::FRAC_BITS]}) -
            $signed({22'd0, neg});
    end
    qv1 = qv0 + 23'sd1;
  end

  // frame store
  logic                        ram_we;
  logic [bir_pkg::ADDR_W-1:0]  ram_addr;
  logic                        load_ok;

  assign load_ok = (pos_x < {3'd0, sw_f}) && (pos_y < {3'd0, sh_f}) && ({1'b0, chan} < ch_f);
  assign ram_we  = in_valid && in_ready && (operation == bir_pkg::OP_LOAD) && load_ok;

  always_comb begin
    if (state == S_IDLE) begin
      ram_addr = {pos_y[bir_pkg::IDX_W-1:0], pos_x[bir_pkg::IDX_W-1:0], chan};
    end else begin
      ram_addr = {(cnt[1] ? y1 : y0), (cnt[0] ? x1 : x0), req_c};
    end
  end

  bir_ram #(
    .WIDTH (bir_pkg::SAMPLE_BITS),
    .DEPTH (bir_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (sample_in),
    .rdata (ram_rdata)
  );

  logic [15:0] res;
  logic        res_err;
  logic [32:0] rnd;

  assign rnd = acc + 33'(1 << (2 * bir_pkg::FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      src_width     <= 9'd256;
      src_height    <= 9'd256;
      dst_width     <= 13'd256;
      dst_height    <= 13'd256;
      channel_count <= 3'd1;
      interp_mode   <= bir_pkg::MODE_BILINEAR;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bir_pkg::CFG_SRC_WIDTH:  src_width     <= cfg_data[8:0];
          bir_pkg::CFG_SRC_HEIGHT: src_height    <= cfg_data[8:0];
          bir_pkg::CFG_DST_WIDTH:  dst_width     <= cfg_data;
          bir_pkg::CFG_DST_HEIGHT: dst_height    <= cfg_data;
          bir_pkg::CFG_CHANNELS:   channel_count <= cfg_data[2:0];
          bir_pkg::CFG_MODE:       interp_mode   <= cfg_data[0];
          default: ;
        endcase
      end

      // in S_DONE the output register is reloaded instead
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid && operation == bir_pkg::OP_REQUEST) begin
            req_x <= pos_x;
            req_y <= pos_y;
            req_c <= chan;
            axis  <= 1'b0;
            cnt   <= '0;
            if ({1'b0, pos_x} >= dw_f || {1'b0, pos_y} >= dh_f ||
                {1'b0, chan} >= ch_f) begin
              res     <= '0;
              res_err <= 1'b1;
              state   <= S_DONE;
            end else begin
              res_err <= 1'b0;
              state   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod  <= mul_p[21:0];
          state <= S_PREP;
        end
        S_PREP: begin
          neg   <= prep_neg;
          state <= S_DIV;
        end
        S_DIV: begin
          if (!div_busy) begin
            if (axis == 1'b0) begin
              x0    <= clamp_idx(qv0, ssel);
              x1    <= clamp_idx(qv1, ssel);
              fx    <= div_quo[bir_pkg::FRAC_BITS-1:0];
              axis  <= 1'b1;
              state <= S_MUL;
            end else begin
              y0    <= clamp_idx(qv0, ssel);
              y1    <= clamp_idx(qv1, ssel);
              fy    <= div_quo[bir_pkg::FRAC_BITS-1:0];
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (interp_mode == bir_pkg::MODE_NEAREST) begin
            res   <= ram_rdata;
            state <= S_DONE;
          end else begin
            // even corner starts a row, odd corner closes it
            if (cnt[0] == 1'b0) begin
              row <= mul_p[23:0];
            end else if (cnt[1] == 1'b0) begin
              top <= row + mul_p[23:0];
            end else begin
              bot <= row + mul_p[23:0];
            end
            cnt   <= cnt + 2'd1;
            state <= (cnt == 2'd3) ? S_BL0 : S_RD;
          end
        end
        S_BL0: begin
          acc   <= mul_p;
          state <= S_BL1;
        end
        S_BL1: begin
          acc   <= acc + mul_p;
          state <= S_RND;
        end
        S_RND: begin
          res   <= rnd[2*bir_pkg::FRAC_BITS +: 16];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            sample_out  <= res;
            range_error <= res_err;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_busy)
    else $error("divider busy while block idle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && range_error) |-> (sample_out == 16'd0))
    else $error("range error with non-zero sample");

  a_we_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE && !div_busy))
    else $error("store written outside idle");
`endif

endmodule
`default_nettype wire
